/* rtl/mct_pkg.sv */
// Package with the constants, codes and types shared by the note tracker files.
package mct_pkg;

  // Channel and note space.
  localparam int CHANNELS = 16;
  localparam int NOTES    = 128;

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int CHAN_W   = 4;
  localparam int DATA_W   = 7;
  localparam int COUNT_W  = 8;
  localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // First channel number that lies outside the tracked range.
  localparam logic [CHAN_W:0] CH_LIMIT = (CHAN_W + 1)'(CHANNELS);

  // Saturation value of the held-note count.
  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

  // Controller numbers that the block acts on.
  localparam logic [DATA_W-1:0] CC_VOLUME  = 7'd7;
  localparam logic [DATA_W-1:0] CC_ALL_OFF = 7'd123;
  localparam logic [DATA_W-1:0] CC_MONO    = 7'd126;
  localparam logic [DATA_W-1:0] CC_POLY    = 7'd127;

  // Sound format register codes.
  localparam logic FMT_BANK = 1'b0;
  localparam logic FMT_SF2  = 1'b1;

  // Message kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_NOTE_ON  = 2'd0,
    KIND_NOTE_OFF = 2'd1,
    KIND_PROGRAM  = 2'd2,
    KIND_CONTROL  = 2'd3
  } kind_e;

  // Synth commands.
  typedef enum logic [1:0] {
    CMD_NONE    = 2'd0,
    CMD_ON      = 2'd1,
    CMD_OFF     = 2'd2,
    CMD_ALL_OFF = 2'd3
  } cmd_e;

  // One input item as held in the input register.
  typedef struct packed {
    kind_e             kind;
    logic [CHAN_W-1:0] channel;
    logic [DATA_W-1:0] first_data;
    logic [DATA_W-1:0] second_data;
    logic              sample_found;
  } in_item_t;

  // One result item.
  typedef struct packed {
    cmd_e               command;
    logic [DATA_W-1:0]  note;
    logic [DATA_W-1:0]  velocity;
    logic [DATA_W-1:0]  program_res;
    logic [COUNT_W-1:0] held_count;
    logic [DATA_W-1:0]  channel_level;
    logic               last;
  } result_t;

endpackage

/* rtl/mct_if.sv */
// Handshake channel interfaces for input items, result items and configuration.
interface mct_in_if;
  import mct_pkg::*;

  logic              valid;
  logic              ready;
  kind_e             kind;
  logic [CHAN_W-1:0] channel;
  logic [DATA_W-1:0] first_data;
  logic [DATA_W-1:0] second_data;
  logic              sample_found;

  modport source (
    output valid, kind, channel, first_data, second_data, sample_found,
    input  ready
  );
  modport sink (
    input  valid, kind, channel, first_data, second_data, sample_found,
    output ready
  );
endinterface

interface mct_out_if;
  import mct_pkg::*;

  logic               valid;
  logic               ready;
  cmd_e               command;
  logic [DATA_W-1:0]  note;
  logic [DATA_W-1:0]  velocity;
  logic [DATA_W-1:0]  program_res;
  logic [COUNT_W-1:0] held_count;
  logic [DATA_W-1:0]  channel_level;
  logic               last;

  modport source (
    output valid, command, note, velocity, program_res, held_count, channel_level, last,
    input  ready
  );
  modport sink (
    input  valid, command, note, velocity, program_res, held_count, channel_level, last,
    output ready
  );
endinterface

interface mct_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (
    output valid, data,
    input  ready
  );
  modport sink (
    input  valid, data,
    output ready
  );
endinterface

/* rtl/mct_out_queue.sv */
// Two-entry result queue that takes up to two result items at once and drains one per cycle while the sink is ready.
module mct_out_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [1:0]              push_n_i,
  input  mct_pkg::result_t        res0_i,
  input  mct_pkg::result_t        res1_i,
  output logic [1:0]              free_o,
  mct_out_if.source               out_o
);
  import mct_pkg::*;

  result_t    entry_q [2];
  logic       rd_ptr_q;
  logic       rd_ptr_d;
  logic [1:0] count_q;
  logic [1:0] count_d;
  logic       pop;
  logic       wr0;
  logic       wr1;

  // A result leaves when the sink takes it.
  assign pop = out_o.valid && out_o.ready;

  // Free slots count the one that drains in this cycle.
  assign free_o = 2'd2 - count_q + {1'b0, pop};

  // New results go behind the ones already queued.
  assign wr0 = rd_ptr_q + count_q[0];
  assign wr1 = ~wr0;

  assign rd_ptr_d = rd_ptr_q ^ pop;
  assign count_d  = count_q - {1'b0, pop} + push_n_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      entry_q[wr0] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      entry_q[wr1] <= res1_i;
    end
  end

  // Head of the queue drives the output channel.
  assign out_o.valid         = (count_q != 2'd0);
  assign out_o.command       = entry_q[rd_ptr_q].command;
  assign out_o.note          = entry_q[rd_ptr_q].note;
  assign out_o.velocity      = entry_q[rd_ptr_q].velocity;
  assign out_o.program_res   = entry_q[rd_ptr_q].program_res;
  assign out_o.held_count    = entry_q[rd_ptr_q].held_count;
  assign out_o.channel_level = entry_q[rd_ptr_q].channel_level;
  assign out_o.last          = entry_q[rd_ptr_q].last;

endmodule

/* rtl/midi_channel_note_tracker.sv */
// Top level of the MIDI channel note tracker.
// Each accepted item waits in an input register until its one or two result items fit in a
// two-entry result queue, and is then processed in a single pass against the per-channel state.
// An item that yields one result can be accepted every cycle while the output is ready; a note
// on in mono mode with the SF2 format yields a note off and a note on, so the sustained rate is
// set by the result queue, which drains one item per cycle while the output is ready.
// Per channel, the velocity map is kept as one held flag per note in a 128-bit row, which reset
// clears at once and which an all-notes-off also clears at once; there is no clearing pass.
module midi_channel_note_tracker (
  input  logic clk_i,
  input  logic rst_ni,
  mct_cfg_if.sink   cfg_i,
  mct_in_if.sink    in_i,
  mct_out_if.source out_o
);
  import mct_pkg::*;

  // Configuration register.
  logic sound_format_q;

  // Input register.
  logic     in_valid_q;
  in_item_t in_q;

  // Per-channel state.
  logic [NOTES-1:0]   vel_nz_q  [CHANNELS];
  logic [COUNT_W-1:0] held_q    [CHANNELS];
  logic [DATA_W-1:0]  prev_q    [CHANNELS];
  logic               mono_q    [CHANNELS];
  logic [DATA_W-1:0]  prog_q    [CHANNELS];
  logic [DATA_W-1:0]  vol_q     [CHANNELS];

  // Next values for the addressed channel.
  logic [NOTES-1:0]   row_d;
  logic [COUNT_W-1:0] held_d;
  logic [DATA_W-1:0]  prev_d;
  logic               mono_d;
  logic [DATA_W-1:0]  prog_d;
  logic [DATA_W-1:0]  vol_d;

  logic [CH_IDX_W-1:0] ch_idx;
  logic                ch_ok;
  logic                fire;
  logic [1:0]          res_n;
  logic [1:0]          push_n;
  logic [1:0]          free;
  result_t             res0;
  result_t             res1;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sound_format_q <= FMT_SF2;
    end else if (cfg_i.valid && cfg_i.ready) begin
      sound_format_q <= cfg_i.data;
    end
  end

  // The input register refills whenever its item moves on.
  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q.kind         <= in_i.kind;
      in_q.channel      <= in_i.channel;
      in_q.first_data   <= in_i.first_data;
      in_q.second_data  <= in_i.second_data;
      in_q.sample_found <= in_i.sample_found;
    end
  end

  assign ch_idx = in_q.channel[CH_IDX_W-1:0];
  assign ch_ok  = ({1'b0, in_q.channel} < CH_LIMIT);

  // Single-pass message processing for the item in the input register.
  always_comb begin
    logic [NOTES-1:0]   row;
    logic [COUNT_W-1:0] held;
    logic [COUNT_W-1:0] held_a;
    logic [DATA_W-1:0]  pn;
    logic [DATA_W-1:0]  d1;
    logic [DATA_W-1:0]  d2;
    logic [DATA_W-1:0]  prog;
    logic               mono;
    logic               accept;
    logic               seen;

    row    = vel_nz_q[ch_idx];
    held   = held_q[ch_idx];
    pn     = prev_q[ch_idx];
    mono   = mono_q[ch_idx];
    prog   = prog_q[ch_idx];
    d1     = in_q.first_data;
    d2     = in_q.second_data;
    held_a = held;
    accept = 1'b1;
    seen   = 1'b0;

    row_d  = row;
    held_d = held;
    prev_d = pn;
    mono_d = mono;
    prog_d = prog;
    vol_d  = vol_q[ch_idx];
    res_n  = 2'd1;
    res0   = '0;
    res1   = '0;

    case (in_q.kind)
      KIND_NOTE_ON: begin
        // Mono mode drops the previous note before the new one.
        if (mono) begin
          row_d[pn] = 1'b0;
          held_a    = '0;
        end
        if (sound_format_q == FMT_BANK) begin
          accept = in_q.sample_found;
        end
        seen = row_d[d1];
        if ((held_a != COUNT_MAX) && !seen && accept) begin
          held_d = mono ? COUNT_W'(1) : held_a + COUNT_W'(1);
        end else begin
          held_d = held_a;
        end
        row_d[d1] = (d2 != '0);
        prev_d    = d1;
        if (mono && (sound_format_q == FMT_SF2)) begin
          res_n            = 2'd2;
          res0.command     = CMD_OFF;
          res0.note        = pn;
          res0.program_res = prog;
          res1.command     = CMD_ON;
          res1.note        = d1;
          res1.velocity    = d2;
          res1.program_res = prog;
        end else begin
          res0.command     = CMD_ON;
          res0.note        = d1;
          res0.velocity    = d2;
          res0.program_res = prog;
        end
      end
      KIND_NOTE_OFF: begin
        if ((held != '0) && row[d1]) begin
          held_d = held - COUNT_W'(1);
        end
        row_d[d1]        = 1'b0;
        res0.command     = CMD_OFF;
        res0.note        = d1;
        res0.program_res = prog;
      end
      KIND_PROGRAM: begin
        row_d            = '0;
        held_d           = '0;
        prog_d           = d1;
        res0.command     = CMD_ALL_OFF;
        res0.program_res = prog;
      end
      default: begin
        // Control change.
        if ((d1 == CC_ALL_OFF) || (d1 == CC_MONO)) begin
          row_d            = '0;
          held_d           = '0;
          res0.command     = CMD_ALL_OFF;
          res0.program_res = prog;
          if (d1 == CC_MONO) begin
            mono_d = 1'b1;
          end
        end else begin
          if (d1 == CC_VOLUME) begin
            vol_d = d2;
          end else if (d1 == CC_POLY) begin
            mono_d = 1'b0;
          end
          res0.command     = CMD_NONE;
          res0.program_res = prog;
        end
      end
    endcase

    // Channel-wide fields reflect the state after the whole item.
    res0.held_count    = held_d;
    res0.channel_level = vol_d;
    res1.held_count    = held_d;
    res1.channel_level = vol_d;
    res0.last          = (res_n == 2'd1);
    res1.last          = 1'b1;

    // An untracked channel gives one empty result.
    if (!ch_ok) begin
      res_n     = 2'd1;
      res0      = '0;
      res0.last = 1'b1;
    end
  end

  // The item is processed once its results fit in the queue.
  assign fire   = in_valid_q && (res_n <= free);
  assign push_n = fire ? res_n : 2'd0;

  // Per-channel state update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        vel_nz_q[c] <= '0;
        held_q[c]   <= '0;
        prev_q[c]   <= '0;
        mono_q[c]   <= 1'b0;
        prog_q[c]   <= '0;
        vol_q[c]    <= '0;
      end
    end else if (fire && ch_ok) begin
      vel_nz_q[ch_idx] <= row_d;
      held_q[ch_idx]   <= held_d;
      prev_q[ch_idx]   <= prev_d;
      mono_q[ch_idx]   <= mono_d;
      prog_q[ch_idx]   <= prog_d;
      vol_q[ch_idx]    <= vol_d;
    end
  end

  // Result queue toward the output channel.
  mct_out_queue u_out_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .res0_i   (res0),
    .res1_i   (res1),
    .free_o   (free),
    .out_o    (out_o)
  );

endmodule
